/* sv/hgps_pkg.sv */
`timescale 1ns / 1ps

package hgps_pkg;

    localparam int FRAC_BITS = 8;
    localparam int EDGE_W    = 10;
    localparam int COUNT_W   = 8;
    localparam int POINT_W   = 24;
    localparam int IDX_W     = 9;
    localparam int EQ_W      = EDGE_W + FRAC_BITS;   // edge in Q format
    localparam int NUM_W     = POINT_W + 1;          // divider remainder
    localparam int WIDE_W    = 29;                   // signed working coordinate
    localparam int DIFF_W    = 21;                   // signed distance component
    localparam int SQ_W      = 2 * DIFF_W;

    localparam logic [15:0] INV_SQRT3_Q16  = 16'd37837;
    localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;

    localparam logic [1:0] REG_CELL_EDGE = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS = 2'd1;
    localparam logic [1:0] REG_GRID_COLS = 2'd2;

    // one item inside the quotient pipeline
    typedef struct packed {
        logic                      vld;
        logic                      inb;
        logic                      top;
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic [NUM_W-1:0]          rf;
        logic [NUM_W-1:0]          ra;
        logic [NUM_W-1:0]          rr;
        logic [IDX_W-1:0]          qf;
        logic [IDX_W-1:0]          qa;
        logic [IDX_W-1:0]          qr;
    } div_item_t;

    function automatic logic signed [POINT_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(2 ** (POINT_W - 1) - 1);
        lo = -WIDE_W'(2 ** (POINT_W - 1));
        if (v > hi) begin
            return hi[POINT_W-1:0];
        end else if (v < lo) begin
            return lo[POINT_W-1:0];
        end
        return v[POINT_W-1:0];
    endfunction

endpackage

/* sv/hgps_div.sv */
`timescale 1ns / 1ps

// Three-lane restoring divider, one quotient bit per stage, MSB first.
module hgps_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [hgps_pkg::EQ_W-1:0]     div_e,
    input  logic [hgps_pkg::EQ_W-1:0]     div_r,
    input  hgps_pkg::div_item_t           in_item,
    output hgps_pkg::div_item_t           out_item
);

    localparam int STAGES = hgps_pkg::IDX_W;
    localparam int CMP_W  = hgps_pkg::NUM_W + STAGES;

    hgps_pkg::div_item_t stage_reg  [STAGES];
    hgps_pkg::div_item_t stage_next [STAGES];

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            localparam int B = STAGES - 1 - k;
            hgps_pkg::div_item_t src;
            logic [CMP_W-1:0] se, sr;

            if (k == 0) begin : g_first
                assign src = in_item;
            end else begin : g_rest
                assign src = stage_reg[k-1];
            end

            assign se = CMP_W'(div_e) << B;
            assign sr = CMP_W'(div_r) << B;

            always_comb begin
                stage_next[k] = src;
                if (CMP_W'(src.rf) >= se) begin
                    stage_next[k].rf    = src.rf - se[hgps_pkg::NUM_W-1:0];
                    stage_next[k].qf[B] = 1'b1;
                end
                if (CMP_W'(src.ra) >= se) begin
                    stage_next[k].ra    = src.ra - se[hgps_pkg::NUM_W-1:0];
                    stage_next[k].qa[B] = 1'b1;
                end
                if (CMP_W'(src.rr) >= sr) begin
                    stage_next[k].rr    = src.rr - sr[hgps_pkg::NUM_W-1:0];
                    stage_next[k].qr[B] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stage_reg[k].vld <= 1'b0;
                end else if (en) begin
                    stage_reg[k] <= stage_next[k];
                end
            end
        end
    endgenerate

    assign out_item = stage_reg[STAGES-1];

endmodule

/* sv/hex_grid_point_snap.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_point_x, s_point_y
// m_        out        m_valid / m_ready   m_snap_x, m_snap_y, m_cell_row,
//                                          m_cell_col, m_in_bounds
// cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One point per cycle unless m_ready stalls; stages: input register, nine
// divider stages, one multiply, one candidate, one square stage, output
// register. The nine-stage restoring divider sets the depth.
// Reset is synchronous on aresetn; it clears valid bits and config registers.
// A stall on m_ready holds every stage in place; s_ready drops with it.
// Grid constants settle after a config transfer: edge products, then height.
module hex_grid_point_snap (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [hgps_pkg::EDGE_W-1:0]          cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [hgps_pkg::POINT_W-1:0]  s_point_x,
    input  logic signed [hgps_pkg::POINT_W-1:0]  s_point_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [hgps_pkg::POINT_W-1:0]  m_snap_x,
    output logic signed [hgps_pkg::POINT_W-1:0]  m_snap_y,
    output logic [hgps_pkg::IDX_W-1:0]           m_cell_row,
    output logic [hgps_pkg::IDX_W-1:0]           m_cell_col,
    output logic                                 m_in_bounds
);

    localparam int EQ_W   = hgps_pkg::EQ_W;
    localparam int PW     = hgps_pkg::POINT_W;
    localparam int WW     = hgps_pkg::WIDE_W;
    localparam int DW     = hgps_pkg::DIFF_W;
    localparam int SW     = hgps_pkg::SQ_W;
    localparam int IW     = hgps_pkg::IDX_W;
    localparam int FB     = hgps_pkg::FRAC_BITS;
    localparam int CW     = hgps_pkg::COUNT_W;
    localparam int MUL_W  = EQ_W + 16;
    localparam int W_W    = EQ_W + CW;
    localparam int H_W    = W_W + 1;
    localparam int PROD_W = EQ_W + IW;

    // ---------------- configuration registers ----------------
    logic [hgps_pkg::EDGE_W-1:0] edge_reg;
    logic [CW-1:0]               rows_reg, cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg <= hgps_pkg::EDGE_W'(32);
            rows_reg <= CW'(12);
            cols_reg <= CW'(10);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hgps_pkg::REG_CELL_EDGE: edge_reg <= cfg_data;
                hgps_pkg::REG_GRID_ROWS: rows_reg <= cfg_data[CW-1:0];
                hgps_pkg::REG_GRID_COLS: cols_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Derived grid constants, two register levels: edge products, then height.
    logic [EQ_W-1:0]  eq_reg, he_reg, po1_reg, rowp_reg;
    logic [EQ_W-1:0]  eq_next, po1_next, rowp_next;
    logic [W_W-1:0]   w_reg;
    logic [H_W-1:0]   h_reg, h_next;
    logic             nogrid_reg;
    logic [MUL_W-1:0] po1_prod, rowp_prod;

    always_comb begin
        eq_next   = {((edge_reg == '0) ? hgps_pkg::EDGE_W'(1) : edge_reg), FB'(0)};
        po1_prod  = MUL_W'(eq_next) * MUL_W'(hgps_pkg::INV_SQRT3_Q16) + MUL_W'(32768);
        rowp_prod = MUL_W'(eq_next) * MUL_W'(hgps_pkg::SQRT3_HALF_Q16) + MUL_W'(32768);
        po1_next  = po1_prod[16 +: EQ_W];
        rowp_next = rowp_prod[16 +: EQ_W];
        h_next    = H_W'({po1_reg, 1'b0}) + H_W'(rowp_reg) * H_W'(rows_reg - CW'(1));
        h_next[FB-1:0] = '0;   // truncate to whole pixels
    end

    always_ff @(posedge aclk) begin
        eq_reg     <= eq_next;
        he_reg     <= eq_next >> 1;
        po1_reg    <= po1_next;
        rowp_reg   <= (rowp_next == '0) ? EQ_W'(1) : rowp_next;
        w_reg      <= W_W'(eq_next) * W_W'(cols_reg);
        h_reg      <= h_next;
        nogrid_reg <= (rows_reg == '0) || (cols_reg == '0);
    end

    // ---------------- pipeline control ----------------
    logic en;
    assign en      = !m_valid || m_ready;   // advance every stage together
    assign s_ready = en;

    // Stage 0: input register
    logic              v0_reg;
    logic signed [PW-1:0] x0_reg, y0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
        if (en) begin
            x0_reg <= s_point_x;
            y0_reg <= s_point_y;
        end
    end

    // Bounds test and divider numerators
    hgps_pkg::div_item_t div_in, div_out;
    logic signed [PW+2:0] xs, py, na, nr;

    always_comb begin
        xs = (PW+3)'(x0_reg);
        py = -(PW+3)'(y0_reg);
        na = xs - $signed((PW+3)'(he_reg));
        nr = py - $signed((PW+3)'(po1_reg));
        div_in     = '0;
        div_in.vld = v0_reg;
        div_in.x   = x0_reg;
        div_in.y   = y0_reg;
        div_in.inb = !(nogrid_reg || xs < 0 || xs > $signed((PW+3)'(w_reg))
                       || y0_reg > 0 || py > $signed((PW+3)'(h_reg)));
        div_in.top = py < $signed((PW+3)'(po1_reg));
        div_in.rf  = (xs < 0) ? '0 : xs[hgps_pkg::NUM_W-1:0];
        div_in.ra  = (na < 0) ? '0 : na[hgps_pkg::NUM_W-1:0];
        div_in.rr  = (nr < 0) ? '0 : nr[hgps_pkg::NUM_W-1:0];
    end

    hgps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .div_e    (eq_reg),
        .div_r    (rowp_reg),
        .in_item  (div_in),
        .out_item (div_out)
    );

    // Multiply stage: scale column and row indexes to coordinates
    logic              vm_reg, inbm_reg, topm_reg;
    logic signed [PW-1:0] xm_reg, ym_reg;
    logic [IW-1:0]     fcm_reg, acm_reg, rm_reg;
    logic [PROD_W-1:0] fpm_reg, apm_reg, rpm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (en) begin
            vm_reg <= div_out.vld;
        end
        if (en) begin
            inbm_reg <= div_out.inb;
            topm_reg <= div_out.top;
            xm_reg   <= div_out.x;
            ym_reg   <= div_out.y;
            fcm_reg  <= div_out.qf;
            acm_reg  <= div_out.qa;
            rm_reg   <= div_out.qr;
            fpm_reg  <= PROD_W'(div_out.qf) * PROD_W'(eq_reg);
            apm_reg  <= PROD_W'(div_out.qa) * PROD_W'(eq_reg);
            rpm_reg  <= PROD_W'(div_out.qr) * PROD_W'(rowp_reg);
        end
    end

    // Candidate stage: centers of both neighbor rows and their offsets
    logic signed [WW-1:0] fx, ax, c0y, c1y, c0x, c1x, xw, yw;
    logic [IW-1:0]        c0c, c1c;

    always_comb begin
        fx  = $signed(WW'(he_reg)) + $signed(WW'(fpm_reg));
        ax  = $signed(WW'(eq_reg)) + $signed(WW'(apm_reg));
        c0y = -($signed(WW'(po1_reg)) + $signed(WW'(rpm_reg)));
        c1y = c0y - $signed(WW'(rowp_reg));
        xw  = WW'(xm_reg);
        yw  = WW'(ym_reg);
        if (rm_reg[0]) begin
            c0x = ax; c0c = acm_reg; c1x = fx; c1c = fcm_reg;
        end else begin
            c0x = fx; c0c = fcm_reg; c1x = ax; c1c = acm_reg;
        end
        // top band: the first row center wins outright
        if (topm_reg) begin
            c0x = fx; c0c = fcm_reg;
        end
    end

    logic             vc_reg, inbc_reg, topc_reg;
    logic signed [WW-1:0] c0x_reg, c1x_reg, c0y_reg, c1y_reg;
    logic [IW-1:0]    c0c_reg, c1c_reg, rc_reg;
    logic signed [DW-1:0] dx0_reg, dy0_reg, dx1_reg, dy1_reg;
    logic signed [WW-1:0] dx0, dy0, dx1, dy1;

    always_comb begin
        dx0 = xw - c0x;
        dy0 = yw - c0y;
        dx1 = xw - c1x;
        dy1 = yw - c1y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vm_reg;
        end
        if (en) begin
            inbc_reg <= inbm_reg;
            topc_reg <= topm_reg;
            c0x_reg  <= c0x;
            c1x_reg  <= c1x;
            c0y_reg  <= topm_reg ? -$signed(WW'(po1_reg)) : c0y;
            c1y_reg  <= c1y;
            c0c_reg  <= c0c;
            c1c_reg  <= c1c;
            rc_reg   <= topm_reg ? '0 : rm_reg;
            dx0_reg  <= dx0[DW-1:0];
            dy0_reg  <= dy0[DW-1:0];
            dx1_reg  <= dx1[DW-1:0];
            dy1_reg  <= dy1[DW-1:0];
        end
    end

    // Square stage
    logic             vq_reg, inbq_reg, topq_reg;
    logic signed [WW-1:0] c0x_q, c1x_q, c0y_q, c1y_q;
    logic [IW-1:0]    c0c_q, c1c_q, rq_reg;
    logic signed [SW-1:0] sx0_reg, sy0_reg, sx1_reg, sy1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vq_reg <= 1'b0;
        end else if (en) begin
            vq_reg <= vc_reg;
        end
        if (en) begin
            inbq_reg <= inbc_reg;
            topq_reg <= topc_reg;
            c0x_q    <= c0x_reg;
            c1x_q    <= c1x_reg;
            c0y_q    <= c0y_reg;
            c1y_q    <= c1y_reg;
            c0c_q    <= c0c_reg;
            c1c_q    <= c1c_reg;
            rq_reg   <= rc_reg;
            sx0_reg  <= SW'(dx0_reg) * SW'(dx0_reg);
            sy0_reg  <= SW'(dy0_reg) * SW'(dy0_reg);
            sx1_reg  <= SW'(dx1_reg) * SW'(dx1_reg);
            sy1_reg  <= SW'(dy1_reg) * SW'(dy1_reg);
        end
    end

    // Compare stage into output register; a tie takes the next row (index + 1)
    logic [SW:0]        d0, d1;
    logic               pick0;
    logic [IW:0]        row_up;
    logic [IW-1:0]      row_sel;

    always_comb begin
        d0      = (SW+1)'(sx0_reg) + (SW+1)'(sy0_reg);
        d1      = (SW+1)'(sx1_reg) + (SW+1)'(sy1_reg);
        pick0   = topq_reg || (d0 < d1);
        row_up  = (IW+1)'(rq_reg) + (IW+1)'(1);
        row_sel = row_up[IW] ? {IW{1'b1}} : row_up[IW-1:0];
    end

    logic             mv_reg, minb_reg;
    logic signed [PW-1:0] msx_reg, msy_reg;
    logic [IW-1:0]    mrow_reg, mcol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (en) begin
            mv_reg <= vq_reg;
        end
        if (en) begin
            minb_reg <= inbq_reg;
            if (!inbq_reg) begin
                msx_reg  <= '0;
                msy_reg  <= '0;
                mrow_reg <= '0;
                mcol_reg <= '0;
            end else if (pick0) begin
                msx_reg  <= hgps_pkg::sat_coord(c0x_q);
                msy_reg  <= hgps_pkg::sat_coord(c0y_q);
                mrow_reg <= rq_reg;
                mcol_reg <= c0c_q;
            end else begin
                msx_reg  <= hgps_pkg::sat_coord(c1x_q);
                msy_reg  <= hgps_pkg::sat_coord(c1y_q);
                mrow_reg <= row_sel;
                mcol_reg <= c1c_q;
            end
        end
    end

    assign m_valid     = mv_reg;
    assign m_snap_x    = msx_reg;
    assign m_snap_y    = msy_reg;
    assign m_cell_row  = mrow_reg;
    assign m_cell_col  = mcol_reg;
    assign m_in_bounds = minb_reg;

endmodule

/* sv/hgps_checker.sv */
`timescale 1ns / 1ps

module hgps_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [hgps_pkg::POINT_W-1:0] m_snap_x,
    input logic signed [hgps_pkg::POINT_W-1:0] m_snap_y,
    input logic [hgps_pkg::IDX_W-1:0]          m_cell_row,
    input logic [hgps_pkg::IDX_W-1:0]          m_cell_col,
    input logic                                m_in_bounds
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_snap_x) && $stable(m_cell_row))
        else $error("result changed while stalled");

    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_bounds |->
            m_snap_x == 0 && m_snap_y == 0 && m_cell_row == 0 && m_cell_col == 0)
        else $error("out-of-bounds result carries nonzero fields");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_bounds |-> m_cell_row <= 256 && m_cell_col <= 255)
        else $error("cell index beyond grid");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled while output free");

endmodule

bind hex_grid_point_snap hgps_checker u_hgps_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_snap_x    (m_snap_x),
    .m_snap_y    (m_snap_y),
    .m_cell_row  (m_cell_row),
    .m_cell_col  (m_cell_col),
    .m_in_bounds (m_in_bounds)
);
